[design/tensor_index_unravel_defines.svh]
// assertion macros for the checker module
`ifndef TENSOR_INDEX_UNRAVEL_DEFINES_SVH
`define TENSOR_INDEX_UNRAVEL_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TIU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tiu check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define TIU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tiu check failed: next-cycle implication");

`endif

[design/tiu_pkg.sv]
`timescale 1ns / 1ps

package tiu_pkg;

   localparam int INDEX_WIDTH     = 64;
   localparam int SIZE_WIDTH      = 32;
   localparam int AXIS_WIDTH      = 3;
   localparam int RANK_WIDTH      = 3;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int SIZE_REGS       = 6;
   localparam int MAX_AXES_DEFAULT = 6;

   // register map
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RANK     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DIM_BASE = 3'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_DIV,
      ST_PUSH
   } state_type;

endpackage

[design/tiu_regs.sv]
`timescale 1ns / 1ps

module tiu_regs
   import tiu_pkg::*;
#(
   parameter int MAX_AXES  = MAX_AXES_DEFAULT,
   parameter int SlotWidth = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic [SlotWidth-1:0]       rd_slot,
   output logic [RANK_WIDTH-1:0]      rank,
   output logic [SIZE_WIDTH-1:0]      rd_size
);

   logic [RANK_WIDTH-1:0] rank_ff;
   logic [SIZE_WIDTH-1:0] size_ff [MAX_AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= RANK_WIDTH'(1);
         for (int i = 0; i < MAX_AXES; i++) begin
            size_ff[i] <= SIZE_WIDTH'(1);
         end
      end else if (csr_valid) begin
         if (csr_index == REG_RANK) begin
            rank_ff <= csr_data[RANK_WIDTH-1:0];
         end
         // slots past the register map keep size 1
         for (int i = 0; i < MAX_AXES; i++) begin
            if (i < SIZE_REGS && csr_index == REG_DIM_BASE + CSR_INDEX_WIDTH'(i)) begin
               size_ff[i] <= csr_data[SIZE_WIDTH-1:0];
            end
         end
      end
   end

   assign rank    = rank_ff;
   assign rd_size = size_ff[rd_slot];

endmodule

[design/tiu_div.sv]
`timescale 1ns / 1ps

module tiu_div
   import tiu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [INDEX_WIDTH-1:0] dividend,
   input  logic [SIZE_WIDTH-1:0]  divisor,
   output logic                   done,
   output logic [INDEX_WIDTH-1:0] quotient,
   output logic [SIZE_WIDTH-1:0]  remainder
);

   localparam int CountWidth = $clog2(INDEX_WIDTH);

   logic                   busy_ff;
   logic                   done_ff;
   logic [CountWidth-1:0]  count_ff;
   logic [INDEX_WIDTH-1:0] work_ff;
   logic [SIZE_WIDTH-1:0]  rem_ff;
   logic [SIZE_WIDTH-1:0]  div_ff;
   logic [SIZE_WIDTH:0]    trial;
   logic                   fits;
   logic [SIZE_WIDTH:0]    diff;

   // restoring step: bring down the next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, work_ff[INDEX_WIDTH-1]};
      fits  = trial >= {1'b0, div_ff};
      diff  = trial - {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && count_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // dividend bits shift out the top while quotient bits shift in the bottom
   always_ff @(posedge clock) begin
      if (start) begin
         count_ff <= '1;
         work_ff  <= dividend;
         rem_ff   <= '0;
         div_ff   <= divisor;
      end else if (busy_ff) begin
         count_ff <= count_ff - CountWidth'(1);
         work_ff  <= {work_ff[INDEX_WIDTH-2:0], fits};
         rem_ff   <= fits ? diff[SIZE_WIDTH-1:0] : trial[SIZE_WIDTH-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = work_ff;
   assign remainder = rem_ff;

endmodule

[design/tensor_index_unravel.sv]
// Mixed-radix unravel of a 64-bit linear index into per-axis coordinates. Each request beat
// yields MAX_AXES response beats, axis MAX_AXES-1 first down to axis 0, which carries last.
// Axes at or above the configured rank read 0; an axis in use of size zero reads 0 with zero_size set
// and leaves the running index alone. One shared restoring divider produces a quotient bit per
// cycle, so each axis in use costs a full divide over all 64 index bits while unused axes only
// pass through; an item is held up further when a response beat is still stalled once the next
// axis is ready. req_ready is high only between items.
// Configuration writes are always taken and must be done while the block is idle.
`timescale 1ns / 1ps

module tensor_index_unravel
   import tiu_pkg::*;
#(
   parameter int MAX_AXES = MAX_AXES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [INDEX_WIDTH-1:0]     req_linear_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [AXIS_WIDTH-1:0]      rsp_axis,
   output logic [SIZE_WIDTH-1:0]      rsp_coordinate,
   output logic                       rsp_zero_size,
   output logic                       rsp_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam int SlotWidth = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

   state_type              state_ff, state_in;
   logic [SlotWidth-1:0]   slot_ff;
   logic [INDEX_WIDTH-1:0] running_ff;
   logic [SIZE_WIDTH-1:0]  coord_ff;
   logic                   zero_ff;
   logic                   rsp_valid_ff;
   logic [AXIS_WIDTH-1:0]  rsp_axis_ff;
   logic [SIZE_WIDTH-1:0]  rsp_coord_ff;
   logic                   rsp_zero_ff;
   logic                   rsp_last_ff;

   logic [RANK_WIDTH-1:0]  rank;
   logic [RANK_WIDTH-1:0]  used;
   logic [SIZE_WIDTH-1:0]  size;
   logic                   slot_active;
   logic                   size_zero;
   logic                   out_free;
   logic                   push;
   logic                   div_start;
   logic                   div_done;
   logic [INDEX_WIDTH-1:0] div_quotient;
   logic [SIZE_WIDTH-1:0]  div_remainder;

   tiu_regs #(
      .MAX_AXES (MAX_AXES)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rd_slot   (slot_ff),
      .rank      (rank),
      .rd_size   (size)
   );

   tiu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (running_ff),
      .divisor   (size),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // rank saturates at the number of slots
   assign used        = (rank > RANK_WIDTH'(MAX_AXES)) ? RANK_WIDTH'(MAX_AXES) : rank;
   assign slot_active = RANK_WIDTH'(slot_ff) < used;
   assign size_zero   = size == '0;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      push      = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (slot_active && !size_zero) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               push     = 1'b1;
               state_in = (slot_ff == '0) ? ST_IDLE : ST_STEP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         running_ff <= req_linear_index;
         slot_ff    <= SlotWidth'(MAX_AXES - 1);
      end
      if (state_ff == ST_STEP) begin
         coord_ff <= '0;
         zero_ff  <= slot_active && size_zero;
      end
      if (state_ff == ST_DIV && div_done) begin
         coord_ff   <= div_remainder;
         running_ff <= div_quotient;
      end
      if (push && slot_ff != '0) begin
         slot_ff <= slot_ff - SlotWidth'(1);
      end
   end

   // output register: holds a beat while the next axis is being worked on
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_axis_ff  <= AXIS_WIDTH'(slot_ff);
         rsp_coord_ff <= coord_ff;
         rsp_zero_ff  <= zero_ff;
         rsp_last_ff  <= slot_ff == '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_axis       = rsp_axis_ff;
   assign rsp_coordinate = rsp_coord_ff;
   assign rsp_zero_size  = rsp_zero_ff;
   assign rsp_last       = rsp_last_ff;
   assign csr_ready      = 1'b1;

endmodule

[design/tiu_checker.sv]
`timescale 1ns / 1ps
`include "tensor_index_unravel_defines.svh"

module tiu_checker
   import tiu_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [AXIS_WIDTH-1:0]      rsp_axis,
   input logic [SIZE_WIDTH-1:0]      rsp_coordinate,
   input logic                       rsp_zero_size,
   input logic                       rsp_last
);

   logic req_beat;
   logic rsp_stall;

   assign req_beat  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // a stalled response beat holds
   `TIU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_coordinate) && $stable(rsp_axis) && $stable(rsp_last))
   // a zero-size axis always reads coordinate 0
   `TIU_ASSERT_NOW(a_zero_coord, clock, reset, rsp_valid && rsp_zero_size, rsp_coordinate == '0)
   // only axis 0 closes the run
   `TIU_ASSERT_NOW(a_last_axis, clock, reset, rsp_valid, rsp_last == (rsp_axis == '0))
   // no new request while a run is still in flight
   `TIU_ASSERT_NOW(a_busy_mid_run, clock, reset, rsp_valid && !rsp_last, !req_ready)
   // once an item is taken the block is busy
   `TIU_ASSERT_NEXT(a_busy_after_req, clock, reset, req_beat, !req_ready)

endmodule

bind tensor_index_unravel tiu_checker u_checker (.*);

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
   import tiu_pkg::*;

   localparam int NUM_AXES    = MAX_AXES_DEFAULT;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RAND_PHASES = 8;
   localparam int PHASE_ITEMS = 37;

   // one past the last size register, writes here must be dropped
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNMAPPED  =
      REG_DIM_BASE + CSR_INDEX_WIDTH'(SIZE_REGS);
   localparam logic [SIZE_WIDTH-1:0]      SIZE_ALL_ONES = '1;
   localparam logic [INDEX_WIDTH-1:0]     INDEX_MAX     = '1;

   typedef enum int {
      GAPS_RANDOM,
      GAPS_NONE,
      GAPS_SPARSE
   } gap_mode_type;

   typedef struct {
      logic [AXIS_WIDTH-1:0] axis;
      logic [SIZE_WIDTH-1:0] coordinate;
      logic                  zero_size;
      logic                  last;
   } coord_beat_type;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic [INDEX_WIDTH-1:0]     req_linear_index = '0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic [AXIS_WIDTH-1:0]      rsp_axis;
   logic [SIZE_WIDTH-1:0]      rsp_coordinate;
   logic                       rsp_zero_size;
   logic                       rsp_last;
   logic                       csr_valid        = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data         = '0;

   // shadow copy of the block's registers
   logic [RANK_WIDTH-1:0] cfg_rank;
   logic [SIZE_WIDTH-1:0] cfg_dim [NUM_AXES];

   logic [SIZE_WIDTH-1:0] shape [NUM_AXES];

   logic [INDEX_WIDTH-1:0] index_queue [$];
   coord_beat_type         expected_coords [$];

   gap_mode_type req_gap_mode = GAPS_NONE;
   gap_mode_type rsp_gap_mode = GAPS_NONE;
   bit           req_taken    = 1'b0;
   bit           req_busy     = 1'b0;
   bit           rsp_taken    = 1'b0;
   bit           csr_taken    = 1'b0;
   int           req_wait     = 0;
   int           rsp_wait     = 0;
   int           mismatches   = 0;
   int           cycle_count  = 0;

   tensor_index_unravel #(
      .MAX_AXES(NUM_AXES)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_linear_index(req_linear_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_axis        (rsp_axis),
      .rsp_coordinate  (rsp_coordinate),
      .rsp_zero_size   (rsp_zero_size),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #6 clock = ~clock;

   function automatic int draw_gap(input gap_mode_type mode);
      case (mode)
         GAPS_NONE:   return 0;
         GAPS_SPARSE: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
         default:     return $urandom_range(0, 14);
      endcase
   endfunction

   // split one linear index over the configured axes, innermost first
   function automatic void unravel_index(input logic [INDEX_WIDTH-1:0] linear);
      logic [INDEX_WIDTH-1:0] running;
      logic [INDEX_WIDTH-1:0] divisor;
      logic [SIZE_WIDTH-1:0]  coord [NUM_AXES];
      logic                   zero_flag [NUM_AXES];
      int                     used;
      coord_beat_type         beat;
      running = linear;
      used = (cfg_rank > NUM_AXES) ? NUM_AXES : int'(cfg_rank);
      for (int a = 0; a < NUM_AXES; a++) begin
         coord[a] = '0;
         zero_flag[a] = 1'b0;
      end
      for (int a = used - 1; a >= 0; a--) begin
         divisor = INDEX_WIDTH'(cfg_dim[a]);
         if (divisor == '0) begin
            zero_flag[a] = 1'b1;
         end else begin
            coord[a] = SIZE_WIDTH'(running % divisor);
            running = running / divisor;
         end
      end
      for (int a = NUM_AXES - 1; a >= 0; a--) begin
         beat.axis = AXIS_WIDTH'(a);
         beat.coordinate = coord[a];
         beat.zero_size = zero_flag[a];
         beat.last = (a == 0);
         expected_coords.push_back(beat);
      end
   endfunction

   function automatic logic [INDEX_WIDTH-1:0] random_index();
      logic [INDEX_WIDTH-1:0] value;
      value = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       value = INDEX_MAX;
         1:       value = '0;
         2, 3:    ;
         default: value = value >> $urandom_range(1, 63);
      endcase
      return value;
   endfunction

   function automatic logic [SIZE_WIDTH-1:0] random_size();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return SIZE_ALL_ONES;
         2:       return SIZE_WIDTH'(1);
         3, 4:    return $urandom;
         5:       return 32'h1 << $urandom_range(0, 31);
         default: return $urandom_range(2, 40);
      endcase
   endfunction

   // request driver
   always @(negedge clock) begin
      if (req_taken) begin
         req_taken = 1'b0;
         req_busy = 1'b0;
         req_wait = draw_gap(req_gap_mode);
      end
      if (!reset && !req_busy) begin
         if (req_wait > 0) begin
            req_wait--;
         end else if (index_queue.size() > 0) begin
            req_linear_index <= index_queue.pop_front();
            req_busy = 1'b1;
         end
      end
      req_valid <= req_busy;
   end

   // response back-pressure, one stall drawn per beat
   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         rsp_wait = draw_gap(rsp_gap_mode);
      end
      if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: tracks register writes, predicts on request beats, checks response beats
   always @(posedge clock) begin
      coord_beat_type want;
      if (reset) begin
         cfg_rank = RANK_WIDTH'(1);
         for (int a = 0; a < NUM_AXES; a++) begin
            cfg_dim[a] = SIZE_WIDTH'(1);
         end
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_RANK) begin
               cfg_rank = csr_data[RANK_WIDTH-1:0];
            end else if (csr_index >= REG_DIM_BASE && csr_index < REG_UNMAPPED) begin
               cfg_dim[csr_index - REG_DIM_BASE] = csr_data;
            end
            csr_taken = 1'b1;
         end
         if (req_valid && req_ready) begin
            unravel_index(req_linear_index);
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1'b1;
            if (expected_coords.size() == 0) begin
               $error("unexpected beat: axis %0d coordinate 0x%0h", rsp_axis, rsp_coordinate);
               mismatches++;
            end else begin
               want = expected_coords.pop_front();
               if (rsp_axis !== want.axis) begin
                  $error("axis: expected %0d, got %0d", want.axis, rsp_axis);
                  mismatches++;
               end
               if (rsp_coordinate !== want.coordinate) begin
                  $error("coordinate: expected 0x%0h, got 0x%0h",
                         want.coordinate, rsp_coordinate);
                  mismatches++;
               end
               if (rsp_zero_size !== want.zero_size) begin
                  $error("zero_size: expected %0b, got %0b", want.zero_size, rsp_zero_size);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(negedge clock); while (!csr_taken);
      csr_taken = 1'b0;
      csr_valid <= 1'b0;
   endtask

   task automatic apply_shape(input logic [RANK_WIDTH-1:0] r);
      write_reg(REG_RANK, CSR_DATA_WIDTH'(r));
      for (int a = 0; a < NUM_AXES; a++) begin
         write_reg(REG_DIM_BASE + CSR_INDEX_WIDTH'(a), shape[a]);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (index_queue.size() != 0 || req_busy || expected_coords.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // registers at their reset values
      index_queue.push_back('0);
      index_queue.push_back(INDEX_MAX);
      wait_drained();

      // unmapped register index, rank and sizes must stay as they were
      write_reg(REG_UNMAPPED, '1);
      index_queue.push_back(64'd12345);
      wait_drained();

      // full rank, small sizes: zero, top of range, wrap past the product
      shape = '{2, 3, 4, 5, 6, 7};
      apply_shape(3'd6);
      index_queue.push_back('0);
      index_queue.push_back(64'd5039);
      index_queue.push_back(64'd5040);
      index_queue.push_back(64'd1234);
      wait_drained();

      // rank above the axis count saturates, largest sizes
      req_gap_mode = GAPS_RANDOM;
      rsp_gap_mode = GAPS_RANDOM;
      shape = '{SIZE_ALL_ONES, SIZE_ALL_ONES, SIZE_ALL_ONES,
                SIZE_ALL_ONES, SIZE_ALL_ONES, SIZE_ALL_ONES};
      apply_shape(3'd7);
      index_queue.push_back(INDEX_MAX);
      index_queue.push_back(64'hFFFF_FFFE_0000_0001);
      index_queue.push_back(64'h0000_0001_0000_0000);
      wait_drained();

      // zero sizes inside the used axes
      shape = '{0, 10, 0, 5, 5, 5};
      apply_shape(3'd3);
      index_queue.push_back(64'd123456);
      index_queue.push_back(INDEX_MAX);
      wait_drained();

      // no axes in use
      apply_shape(3'd0);
      index_queue.push_back(INDEX_MAX);
      index_queue.push_back(64'h5555_5555_5555_5555);
      wait_drained();

      shape = '{1, 1, 1, 1, 1, 32'h8000_0000};
      apply_shape(3'd6);
      index_queue.push_back(INDEX_MAX);
      wait_drained();

      for (int p = 0; p < RAND_PHASES; p++) begin
         logic [RANK_WIDTH-1:0] r;
         case ($urandom_range(0, 9))
            0:       r = 3'd0;
            1:       r = 3'd7;
            default: r = RANK_WIDTH'($urandom_range(1, 6));
         endcase
         for (int a = 0; a < NUM_AXES; a++) begin
            shape[a] = random_size();
         end
         apply_shape(r);
         req_gap_mode = gap_mode_type'($urandom_range(0, 2));
         rsp_gap_mode = gap_mode_type'($urandom_range(0, 2));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            index_queue.push_back(random_index());
         end
         wait_drained();
      end

      repeat (16) @(negedge clock);
      if (mismatches == 0 && expected_coords.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
